// ----- rtl/ofd_pkg.sv -----
// ---------------------------------------------------------------------------
// ofd_pkg
// Shared constants and types for the optical flow frame deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package ofd_pkg;

  localparam int unsigned PAY_LEN = 14;
  localparam int unsigned IDX_W   = $clog2(PAY_LEN);
  localparam int unsigned POS_W   = 5;

  localparam logic [POS_W-1:0] HDR_LEN      = 5'd4;
  localparam logic [POS_W-1:0] LAST_PAY_POS = 5'd17;
  localparam logic [POS_W-1:0] CR_POS       = 5'd18;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // last member sits in the lowest bits
  typedef struct packed {
    logic        [31:0] frame_time;
    logic signed [7:0]  sub_y;
    logic signed [7:0]  sub_x;
    logic signed [7:0]  delta_z;
    logic        [7:0]  lightness;
    logic        [7:0]  reference;
    logic signed [7:0]  delta_y;
    logic signed [7:0]  delta_x;
    logic        [7:0]  quality;
    logic        [7:0]  reserved_byte;
  } ofd_result_t;

  localparam int unsigned OUT_W = $bits(ofd_result_t);

  // frame header "#JB#"
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h23;
      2'd1:    b = 8'h4A;
      2'd2:    b = 8'h42;
      default: b = 8'h23;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ofd_parser.sv -----
// ---------------------------------------------------------------------------
// ofd_parser
// Frame position tracking, payload store and checksum for one byte a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ofd_parser (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 byte_valid,
  input  wire  [7:0]          byte_data,
  output logic                res_valid,
  output ofd_pkg::ofd_result_t res_data
);

  logic [ofd_pkg::POS_W-1:0] pos_r;
  logic [ofd_pkg::POS_W-1:0] pos_nxt;
  logic [7:0]                sum_r;
  logic [7:0]                sum_nxt;
  logic [7:0]                store_r [ofd_pkg::PAY_LEN];
  logic                      wr_en;
  logic [ofd_pkg::IDX_W-1:0] wr_idx;
  logic [ofd_pkg::POS_W-1:0] pay_off;

  assign pay_off = pos_r - ofd_pkg::HDR_LEN;
  assign wr_idx  = pay_off[ofd_pkg::IDX_W-1:0];

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    wr_en     = 1'b0;
    res_valid = 1'b0;
    if (byte_valid) begin
      if (pos_r < ofd_pkg::HDR_LEN) begin
        // mismatch restarts without rechecking this byte
        if (byte_data != ofd_pkg::hdr_byte(pos_r[1:0])) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + 5'd1;
          sum_nxt = '0;
        end
      end else if (pos_r <= ofd_pkg::LAST_PAY_POS) begin
        wr_en   = 1'b1;
        sum_nxt = sum_r + byte_data;
        pos_nxt = pos_r + 5'd1;
      end else if (pos_r == ofd_pkg::CR_POS) begin
        if (sum_r != 8'd0 || byte_data != ofd_pkg::BYTE_CR) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end else begin
        pos_nxt   = '0;
        res_valid = (byte_data == ofd_pkg::BYTE_LF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= byte_data;
    end
  end

  always_comb begin
    res_data.reserved_byte = store_r[0];
    res_data.quality       = store_r[1];
    res_data.delta_x       = store_r[2];
    res_data.delta_y       = store_r[3];
    res_data.reference     = store_r[4];
    res_data.lightness     = store_r[5];
    res_data.delta_z       = store_r[6];
    res_data.sub_x         = store_r[7];
    res_data.sub_y         = store_r[8];
    // little-endian timestamp
    res_data.frame_time    = {store_r[12], store_r[11], store_r[10], store_r[9]};
  end

endmodule

`default_nettype wire

// ----- rtl/optical_flow_frame_deframer_core.sv -----
// ---------------------------------------------------------------------------
// optical_flow_frame_deframer_core
// Finds "#JB#" + 14 payload bytes + CR LF frames in a serial byte stream and
// emits the payload fields of each frame with a good checksum.
// ---------------------------------------------------------------------------
//  channel | dir | payload                          | width
//  in_     | in  | rx_byte                          | 8
//  out_    | out | payload fields of one good frame | 104
//
//  one byte is taken per cycle while in_tready is high; the frame state updates in the accepting cycle
//  a result appears in the output register in the cycle after the LF byte is accepted
//  in_tready drops only while a result sits unclaimed and out_tready is low
//  rst_n (synchronous) returns the parser to the first header byte and
//  empties the output register; the payload store keeps its contents
// ---------------------------------------------------------------------------
`default_nettype none

module optical_flow_frame_deframer_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [7:0]                  in_tdata,   // [7:0] rx_byte
  output logic                        out_tvalid,
  input  wire                         out_tready,
  // [7:0] reserved_byte, [15:8] quality, [23:16] delta_x, [31:24] delta_y,
  // [39:32] reference, [47:40] lightness, [55:48] delta_z, [63:56] sub_x,
  // [71:64] sub_y, [103:72] frame_time
  output logic [ofd_pkg::OUT_W-1:0]   out_tdata
);

  logic                 in_accept;
  logic                 res_valid;
  ofd_pkg::ofd_result_t res_data;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  ofd_pkg::ofd_result_t out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  ofd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_accept),
    .byte_data  (in_tdata),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/ofd_checker.sv -----
// ---------------------------------------------------------------------------
// ofd_checker
// Port-level checks for the deframer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ofd_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_tvalid,
  input wire                       in_tready,
  input wire [7:0]                 in_tdata,
  input wire                       out_tvalid,
  input wire                       out_tready,
  input wire [ofd_pkg::OUT_W-1:0]  out_tdata
);

  // register is cleared by reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word present after reset");

  // a new result only follows an accepted LF word
  a_result_after_lf: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tdata == ofd_pkg::BYTE_LF))
    else $error("result without a preceding LF word");

  // input only stalls behind an unclaimed result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with output free");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output word changed while stalled");

endmodule

bind optical_flow_frame_deframer_core ofd_checker u_ofd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Stream testbench for the optical flow frame deframer core. Serial bytes go
// in one word at a time, with random gaps on the input and random stalls on
// the result side. A scoreboard tracks the frame parser and checks each
// emitted frame field by field. The stimulus is mostly well-formed "#JB#"
// frames with random payloads, plus broken headers, bad checksums, missing
// CR or LF, and noise bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // header bytes, position 0 in the lowest byte: '#','J','B','#'
  localparam logic [31:0] FRAME_HDR   = {8'h23, 8'h42, 8'h4A, 8'h23};
  localparam int          RAND_BYTES  = 1750;
  localparam int          MAX_SHOWN   = 10;

  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_CR, FR_BAD_LF} frame_kind_t;

  class flow_frame_scoreboard;
    logic [ofd_pkg::POS_W-1:0] frame_pos;
    logic [7:0]                frame_sum;
    logic [7:0]                payload [ofd_pkg::PAY_LEN];
    ofd_pkg::ofd_result_t      frames_due [$];
    int                        errors;
    int                        shown;

    function new();
      frame_pos = '0;
      frame_sum = '0;
      foreach (payload[i]) payload[i] = '0;
      errors = 0;
      shown  = 0;
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(logic [7:0] b);
      ofd_pkg::ofd_result_t r;
      if (frame_pos < ofd_pkg::HDR_LEN) begin
        if (b != FRAME_HDR[frame_pos[1:0]*8 +: 8]) begin
          frame_pos = '0;
        end else begin
          frame_pos = frame_pos + 1'b1;
          frame_sum = '0;
        end
      end else if (frame_pos <= ofd_pkg::LAST_PAY_POS) begin
        payload[frame_pos - ofd_pkg::HDR_LEN] = b;
        frame_sum = frame_sum + b;
        frame_pos = frame_pos + 1'b1;
      end else if (frame_pos == ofd_pkg::CR_POS) begin
        if (frame_sum != 8'd0 || b != ofd_pkg::BYTE_CR) frame_pos = '0;
        else frame_pos = frame_pos + 1'b1;
      end else begin
        frame_pos = '0;
        if (b == ofd_pkg::BYTE_LF) begin
          r.reserved_byte = payload[0];
          r.quality       = payload[1];
          r.delta_x       = payload[2];
          r.delta_y       = payload[3];
          r.reference     = payload[4];
          r.lightness     = payload[5];
          r.delta_z       = payload[6];
          r.sub_x         = payload[7];
          r.sub_y         = payload[8];
          r.frame_time    = {payload[12], payload[11], payload[10], payload[9]};
          frames_due.push_back(r);
        end
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (shown < MAX_SHOWN) begin
        shown++;
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got)
        flag($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    endfunction

    function void check_frame(ofd_pkg::ofd_result_t got);
      ofd_pkg::ofd_result_t want;
      if (frames_due.size() == 0) begin
        flag($sformatf("unexpected result word %0h", got));
        return;
      end
      want = frames_due.pop_front();
      cmp_field("reserved_byte", want.reserved_byte, got.reserved_byte);
      cmp_field("quality", want.quality, got.quality);
      cmp_field("delta_x", $unsigned(want.delta_x), $unsigned(got.delta_x));
      cmp_field("delta_y", $unsigned(want.delta_y), $unsigned(got.delta_y));
      cmp_field("reference", want.reference, got.reference);
      cmp_field("lightness", want.lightness, got.lightness);
      cmp_field("delta_z", $unsigned(want.delta_z), $unsigned(got.delta_z));
      cmp_field("sub_x", $unsigned(want.sub_x), $unsigned(got.sub_x));
      cmp_field("sub_y", $unsigned(want.sub_y), $unsigned(got.sub_y));
      cmp_field("frame_time", want.frame_time, got.frame_time);
    endfunction

    function int final_errors();
      if (frames_due.size() != 0)
        flag($sformatf("%0d frames never emitted", frames_due.size()));
      return errors;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [ofd_pkg::OUT_W-1:0] out_tdata;

  flow_frame_scoreboard sb = new();
  int bytes_sent = 0;
  int in_quiet   = 0;
  int out_quiet  = 0;

  optical_flow_frame_deframer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int pick_gap(ref int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(in_quiet);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_header();
    for (int i = 0; i < 4; i++) send_byte(FRAME_HDR[i*8 +: 8]);
  endtask

  // body holds payload bytes 0..12, the checksum byte is derived here
  task automatic send_frame(input frame_kind_t kind, input logic [7:0] body [13]);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    send_header();
    foreach (body[i]) begin
      send_byte(body[i]);
      sum = sum + body[i];
    end
    sum = -sum;
    if (kind == FR_BAD_SUM) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum);
    if (kind == FR_BAD_CR) begin
      do b = 8'($urandom); while (b == ofd_pkg::BYTE_CR);
      send_byte(b);
    end else begin
      send_byte(ofd_pkg::BYTE_CR);
    end
    if (kind == FR_BAD_LF) begin
      do b = 8'($urandom); while (b == ofd_pkg::BYTE_LF);
      send_byte(b);
    end else begin
      send_byte(ofd_pkg::BYTE_LF);
    end
  endtask

  task automatic send_random_frame(input frame_kind_t kind);
    logic [7:0] body [13];
    foreach (body[i]) body[i] = 8'($urandom);
    send_frame(kind, body);
  endtask

  // part of a header, then a byte that breaks it
  task automatic send_broken_header();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_byte(FRAME_HDR[i*8 +: 8]);
    if ($urandom_range(0, 1) == 0 && n != 0 && n != 3) begin
      b = 8'h23;
    end else begin
      do b = 8'($urandom); while (b == FRAME_HDR[n*8 +: 8]);
    end
    send_byte(b);
  endtask

  // a result word is taken when out_tvalid and out_tready are both high
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_frame(ofd_pkg::ofd_result_t'(out_tdata));
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata);
  end

  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        hold = pick_gap(out_quiet);
      end
    end
  end

  initial begin
    logic [7:0] body [13];
    int         r;
    int         guard;
    int         errs;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all-zero payload, then all-ones payload
    foreach (body[i]) body[i] = 8'h00;
    send_frame(FR_GOOD, body);
    foreach (body[i]) body[i] = 8'hFF;
    send_frame(FR_GOOD, body);
    // signed extremes and the largest timestamp
    body = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h80,
             8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(FR_GOOD, body);
    // '#' that breaks a header is not taken as a new first header byte
    send_byte(8'h23);
    send_byte(8'h23);
    send_byte(8'h4A);
    send_byte(8'h42);
    send_byte(8'h23);
    send_byte(8'h55);
    send_random_frame(FR_BAD_SUM);
    send_random_frame(FR_BAD_CR);
    send_random_frame(FR_BAD_LF);
    send_random_frame(FR_GOOD);

    while (bytes_sent < RAND_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_random_frame(FR_GOOD);
      else if (r < 78) send_random_frame(FR_BAD_SUM);
      else if (r < 83) send_random_frame(FR_BAD_CR);
      else if (r < 88) send_random_frame(FR_BAD_LF);
      else if (r < 95) send_broken_header();
      else repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    guard = 0;
    while (sb.frames_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    errs = sb.final_errors();
    if (errs == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
